// ===== src/per_task_mailbox_queues_top_macros.svh =====
// Assertion macros shared by the mailbox queue block.
`ifndef PER_TASK_MAILBOX_QUEUES_TOP_MACROS_SVH
`define PER_TASK_MAILBOX_QUEUES_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define MBXQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by a consequence in the next clock cycle.
`define MBXQ_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`else

`define MBXQ_ASSERT(lbl, clk, rst, prop, msg)
`define MBXQ_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg)

`endif

`endif

// ===== src/mbxq_pkg.sv =====
package mbxq_pkg;

   localparam int NUM_TASKS   = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_PAYLOAD = 256;

   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W      = $clog2(MAX_PAYLOAD + 1);
   localparam int MSG_ADDR_W = TASK_W + SLOT_W;

   // A flush aimed at this target empties the caller's own queue.
   localparam logic [7:0] FLUSH_SELF = 8'hFF;

   typedef enum logic [2:0] {
      MODE_SEND        = 3'd0,
      MODE_RECEIVE     = 3'd1,
      MODE_PEEK        = 3'd2,
      MODE_COUNT       = 3'd3,
      MODE_FLUSH       = 3'd4,
      MODE_READ_STATS  = 3'd5,
      MODE_CLEAR_STATS = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
      logic [CNT_W-1:0]  count;
   } ptr_entry_type;

   typedef struct packed {
      logic [3:0]       snd;
      logic [7:0]       typ;
      logic [7:0]       flg;
      logic [LEN_W-1:0] len;
      logic [31:0]      hdl;
   } msg_entry_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [TASK_W-1:0]   addr;
      ptr_entry_type       wr_data;
   } ptr_cmd_type;

   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [MSG_ADDR_W-1:0] addr;
      msg_entry_type         wr_data;
   } msg_cmd_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] result;
      if (slot == SLOT_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = slot + SLOT_W'(1);
      end
      return result;
   endfunction

   function automatic logic [TASK_W-1:0] to_task(input logic [7:0] value);
      return TASK_W'(value);
   endfunction

endpackage

// ===== src/mbxq_ptr_table.sv =====
module mbxq_ptr_table (
   input  logic                   clock,
   input  logic                   reset,
   input  mbxq_pkg::ptr_cmd_type  cmd,
   output mbxq_pkg::ptr_entry_type rd_data
);

   localparam int DEPTH = 2 ** mbxq_pkg::TASK_W;

   mbxq_pkg::ptr_entry_type mem [0:DEPTH-1];
   logic [DEPTH-1:0]        valid_ff;
   mbxq_pkg::ptr_entry_type rd_data_ff;
   logic                    rd_valid_ff;

   // Entries never written since reset read as all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/mbxq_msg_store.sv =====
module mbxq_msg_store (
   input  logic                    clock,
   input  mbxq_pkg::msg_cmd_type   cmd,
   output mbxq_pkg::msg_entry_type rd_data
);

   localparam int DEPTH = 2 ** mbxq_pkg::MSG_ADDR_W;

   mbxq_pkg::msg_entry_type mem [0:DEPTH-1];
   mbxq_pkg::msg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/per_task_mailbox_queues_top.sv =====
// Mailbox with one circular message queue per task.
// Requests arrive on the req_ channel and each produces exactly one result on
// the rsp_ channel; a transfer happens on a rising edge where valid is high
// and stall is low. The mode selects send, receive, peek, count, flush, read
// stats or clear stats.
// Per-task head, tail and count live in a small pointer memory; the messages
// live in a message memory addressed by task and slot. Both register their
// read data.
// A request occupies the block for its pointer read cycle, then its update and
// result cycle; a receive or peek that finds a message has its message memory
// read cycle between those. The result is valid the cycle after the last of
// those cycles, and a new request may be taken in that same cycle.
// The result sits in an output register. While the receiver stalls, the block
// still accepts one more request and carries it up to its final cycle, then
// holds there, with no state change, until the output register is free.
// Reset clears all queue pointers (through per-entry valid bits in the pointer
// memory) and the three statistics counters.
`include "per_task_mailbox_queues_top_macros.svh"

module per_task_mailbox_queues_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_caller_task,
   input  logic signed [7:0] req_target_task,
   input  logic [7:0]  req_msg_type,
   input  logic [7:0]  req_msg_flags,
   input  logic [9:0]  req_msg_size,
   input  logic [31:0] req_payload_handle,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_sender,
   output logic [7:0]  rsp_out_type,
   output logic [7:0]  rsp_out_flags,
   output logic [8:0]  rsp_out_size,
   output logic [31:0] rsp_out_handle,
   output logic [4:0]  rsp_count_value,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_full_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PTR,
      ST_DATA
   } state_type;

   typedef struct packed {
      mbxq_pkg::status_type status;
      logic [3:0]           sender;
      logic [7:0]           msg_type;
      logic [7:0]           flags;
      logic [8:0]           size;
      logic [31:0]          handle;
      logic [4:0]           count;
      logic [31:0]          sent;
      logic [31:0]          received;
      logic [31:0]          full;
   } rsp_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic [31:0] sent_ff, sent_in;
   logic [31:0] received_ff, received_in;
   logic [31:0] full_ff, full_in;

   // Request payload, captured on the accepting transfer.
   logic [2:0]  mode_ff;
   logic [3:0]  caller_ff;
   logic [7:0]  target_ff;
   logic [7:0]  type_ff;
   logic [7:0]  flags_ff;
   logic [9:0]  size_ff;
   logic [31:0] handle_ff;
   logic [mbxq_pkg::TASK_W-1:0] ptr_addr_ff;

   logic [mbxq_pkg::TASK_W-1:0] sel_addr;
   mbxq_pkg::ptr_cmd_type   ptr_cmd;
   mbxq_pkg::ptr_entry_type ptr_cur;
   mbxq_pkg::msg_cmd_type   msg_cmd;
   mbxq_pkg::msg_entry_type msg_cur;

   logic    out_free;
   logic    finish;
   logic    caller_ok;
   logic    target_ok;
   logic    flush_ok;
   logic    size_ok;
   logic    is_full;
   rsp_type result;

   mbxq_ptr_table u_ptr_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ptr_cmd),
      .rd_data (ptr_cur)
   );

   mbxq_msg_store u_msg_store (
      .clock   (clock),
      .cmd     (msg_cmd),
      .rd_data (msg_cur)
   );

   // The pointer memory is read at the accepting edge, so the queue address
   // comes straight from the request ports.
   always_comb begin
      unique case (req_mode)
         mbxq_pkg::MODE_SEND: begin
            sel_addr = mbxq_pkg::to_task(req_target_task);
         end
         mbxq_pkg::MODE_FLUSH: begin
            if (req_target_task == mbxq_pkg::FLUSH_SELF) begin
               sel_addr = mbxq_pkg::to_task(8'(req_caller_task));
            end else begin
               sel_addr = mbxq_pkg::to_task(req_target_task);
            end
         end
         default: begin
            sel_addr = mbxq_pkg::to_task(8'(req_caller_task));
         end
      endcase
   end

   // Range checks on the registered request.
   assign caller_ok = 32'(caller_ff) < mbxq_pkg::NUM_TASKS;
   assign target_ok = !target_ff[7] && (32'(target_ff[6:0]) < mbxq_pkg::NUM_TASKS);
   assign flush_ok  = (target_ff == mbxq_pkg::FLUSH_SELF) ? caller_ok : target_ok;
   assign size_ok   = 32'(size_ff) <= mbxq_pkg::MAX_PAYLOAD;
   assign is_full   = ptr_cur.count == mbxq_pkg::CNT_W'(mbxq_pkg::QUEUE_DEPTH);

   // The final cycle of a request may only complete, and only commit its
   // side effects, once the output register can take the result.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      sent_in      = sent_ff;
      received_in  = received_ff;
      full_in      = full_ff;
      result       = '0;
      finish       = 1'b0;
      ptr_cmd      = '0;
      msg_cmd      = '0;

      ptr_cmd.addr            = ptr_addr_ff;
      msg_cmd.addr            = {ptr_addr_ff, ptr_cur.tail};
      msg_cmd.wr_data.snd     = caller_ff;
      msg_cmd.wr_data.typ     = type_ff;
      msg_cmd.wr_data.flg     = flags_ff;
      msg_cmd.wr_data.len     = mbxq_pkg::LEN_W'(size_ff);
      msg_cmd.wr_data.hdl     = handle_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ptr_cmd.rd_en = 1'b1;
               ptr_cmd.addr  = sel_addr;
               state_in      = ST_PTR;
            end
         end
         ST_PTR: begin
            unique case (mode_ff) inside
               mbxq_pkg::MODE_SEND: begin
                  finish = 1'b1;
                  if (!target_ok || !size_ok) begin
                     result.status = mbxq_pkg::STATUS_INVALID;
                  end else if (is_full) begin
                     result.status = mbxq_pkg::STATUS_FULL;
                     if (out_free) begin
                        full_in = full_ff + 32'd1;
                     end
                  end else if (out_free) begin
                     msg_cmd.wr_en         = 1'b1;
                     ptr_cmd.wr_en         = 1'b1;
                     ptr_cmd.wr_data.head  = ptr_cur.head;
                     ptr_cmd.wr_data.tail  = mbxq_pkg::next_slot(ptr_cur.tail);
                     ptr_cmd.wr_data.count = ptr_cur.count + mbxq_pkg::CNT_W'(1);
                     sent_in               = sent_ff + 32'd1;
                  end
               end
               mbxq_pkg::MODE_RECEIVE, mbxq_pkg::MODE_PEEK: begin
                  if (!caller_ok) begin
                     finish        = 1'b1;
                     result.status = mbxq_pkg::STATUS_INVALID;
                  end else if (ptr_cur.count == '0) begin
                     finish        = 1'b1;
                     result.status = mbxq_pkg::STATUS_EMPTY;
                  end else begin
                     msg_cmd.rd_en = 1'b1;
                     msg_cmd.addr  = {ptr_addr_ff, ptr_cur.head};
                     state_in      = ST_DATA;
                  end
               end
               mbxq_pkg::MODE_COUNT: begin
                  finish = 1'b1;
                  if (!caller_ok) begin
                     result.status = mbxq_pkg::STATUS_INVALID;
                  end else begin
                     result.count = 5'(ptr_cur.count);
                  end
               end
               mbxq_pkg::MODE_FLUSH: begin
                  finish = 1'b1;
                  if (!flush_ok) begin
                     result.status = mbxq_pkg::STATUS_INVALID;
                  end else begin
                     result.count = 5'(ptr_cur.count);
                     if (out_free) begin
                        ptr_cmd.wr_en   = 1'b1;
                        ptr_cmd.wr_data = '0;
                     end
                  end
               end
               mbxq_pkg::MODE_READ_STATS: begin
                  finish          = 1'b1;
                  result.sent     = sent_ff;
                  result.received = received_ff;
                  result.full     = full_ff;
               end
               mbxq_pkg::MODE_CLEAR_STATS: begin
                  finish = 1'b1;
                  if (out_free) begin
                     sent_in     = '0;
                     received_in = '0;
                     full_in     = '0;
                  end
               end
               default: begin
                  finish        = 1'b1;
                  result.status = mbxq_pkg::STATUS_INVALID;
               end
            endcase
         end
         ST_DATA: begin
            // Message memory data for the head slot is ready; the pointer
            // read data is still held from the pointer stage.
            finish          = 1'b1;
            result.sender   = msg_cur.snd;
            result.msg_type = msg_cur.typ;
            result.flags    = msg_cur.flg;
            result.size     = 9'(msg_cur.len);
            result.handle   = msg_cur.hdl;
            if (out_free && (mode_ff == mbxq_pkg::MODE_RECEIVE)) begin
               ptr_cmd.wr_en         = 1'b1;
               ptr_cmd.wr_data.head  = mbxq_pkg::next_slot(ptr_cur.head);
               ptr_cmd.wr_data.tail  = ptr_cur.tail;
               ptr_cmd.wr_data.count = ptr_cur.count - mbxq_pkg::CNT_W'(1);
               received_in           = received_ff + 32'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
         received_ff  <= '0;
         full_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sent_ff      <= sent_in;
         received_ff  <= received_in;
         full_ff      <= full_in;
      end
      rsp_ff <= rsp_in;
      if ((state_ff == ST_IDLE) && req_valid) begin
         mode_ff     <= req_mode;
         caller_ff   <= req_caller_task;
         target_ff   <= req_target_task;
         type_ff     <= req_msg_type;
         flags_ff    <= req_msg_flags;
         size_ff     <= req_msg_size;
         handle_ff   <= req_payload_handle;
         ptr_addr_ff <= sel_addr;
      end
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_sender         = rsp_ff.sender;
   assign rsp_out_type       = rsp_ff.msg_type;
   assign rsp_out_flags      = rsp_ff.flags;
   assign rsp_out_size       = rsp_ff.size;
   assign rsp_out_handle     = rsp_ff.handle;
   assign rsp_count_value    = rsp_ff.count;
   assign rsp_sent_count     = rsp_ff.sent;
   assign rsp_received_count = rsp_ff.received;
   assign rsp_full_count     = rsp_ff.full;

   `MBXQ_ASSERT_NEXT(a_accept_reads_ptr, clock, reset, req_valid && !req_stall,
                     state_ff == ST_PTR, "accepted request did not move to the pointer stage")
   `MBXQ_ASSERT(a_ptr_no_overlap, clock, reset, !(ptr_cmd.rd_en && ptr_cmd.wr_en),
                "pointer memory read and write in the same cycle")
   `MBXQ_ASSERT(a_count_bound, clock, reset,
                (state_ff == ST_PTR) |->
                (ptr_cur.count <= mbxq_pkg::CNT_W'(mbxq_pkg::QUEUE_DEPTH)),
                "queue count above depth")
   `MBXQ_ASSERT(a_no_write_when_full, clock, reset, msg_cmd.wr_en |-> !is_full,
                "message written into a full queue")
   `MBXQ_ASSERT_NEXT(a_msg_read_to_data, clock, reset, msg_cmd.rd_en,
                     state_ff == ST_DATA, "message read not followed by the data stage")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the per-task mailbox queue block.
//
// A queue of requests is built at time zero. It holds a short directed
// opening and then random sequences: bursts of sends into one task's queue,
// bursts of receives and peeks that drain a queue, flushes, count and
// statistics requests, and fully random noise requests. A clocked driver
// offers those requests on the req_ channel. At each accepted transfer it runs
// the request through a behavioral mirror of the mailbox and queues the
// expected response. A clocked monitor compares every accepted response with
// the oldest expected response.
module testbench;
   import mbxq_pkg::*;

   // Mode 7 has no meaning in the block and must be rejected.
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   localparam int HOLD_AT        = 200;   // accepted requests before the long stall
   localparam int LONG_HOLD      = 400;   // length of the long receiver stall
   localparam int QUIET_TAIL     = 80;    // last requests run with no idling
   localparam int RANDOM_TARGET  = 760;   // minimum number of requests in the run
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  caller;
      logic [7:0]  target;
      logic [7:0]  msg_type;
      logic [7:0]  msg_flags;
      logic [9:0]  size;
      logic [31:0] handle;
      logic        drain_first;   // hold this request until nothing is awaited
   } mbx_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  sender;
      logic [7:0]  out_type;
      logic [7:0]  out_flags;
      logic [8:0]  out_size;
      logic [31:0] out_handle;
      logic [4:0]  count_value;
      logic [31:0] sent_count;
      logic [31:0] received_count;
      logic [31:0] full_count;
   } mbx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [3:0]  req_caller_task = '0;
   logic signed [7:0] req_target_task = '0;
   logic [7:0]  req_msg_type = '0;
   logic [7:0]  req_msg_flags = '0;
   logic [9:0]  req_msg_size = '0;
   logic [31:0] req_payload_handle = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_sender;
   logic [7:0]  rsp_out_type;
   logic [7:0]  rsp_out_flags;
   logic [8:0]  rsp_out_size;
   logic [31:0] rsp_out_handle;
   logic [4:0]  rsp_count_value;
   logic [31:0] rsp_sent_count;
   logic [31:0] rsp_received_count;
   logic [31:0] rsp_full_count;

   per_task_mailbox_queues_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_caller_task    (req_caller_task),
      .req_target_task    (req_target_task),
      .req_msg_type       (req_msg_type),
      .req_msg_flags      (req_msg_flags),
      .req_msg_size       (req_msg_size),
      .req_payload_handle (req_payload_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_sender         (rsp_sender),
      .rsp_out_type       (rsp_out_type),
      .rsp_out_flags      (rsp_out_flags),
      .rsp_out_size       (rsp_out_size),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_count_value    (rsp_count_value),
      .rsp_sent_count     (rsp_sent_count),
      .rsp_received_count (rsp_received_count),
      .rsp_full_count     (rsp_full_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mirror of the mailbox contents. Each task's queue is a ring of
   // QUEUE_DEPTH entries described by its head slot and its fill level.
   msg_entry_type mirror_store [NUM_TASKS][QUEUE_DEPTH];
   int            mirror_head  [NUM_TASKS];
   int            mirror_count [NUM_TASKS];
   logic [31:0]   sent_tally;
   logic [31:0]   received_tally;
   logic [31:0]   full_tally;

   mbx_request_type pending_requests [$];
   mbx_result_type  awaited_responses [$];
   mbx_request_type offered_request;

   // Both counters are updated with nonblocking assignments, so any process
   // that reads them at a clock edge sees the values from before that edge.
   int accepted_requests  = 0;
   int responses_checked  = 0;
   int total_requests     = RANDOM_TARGET;
   int mismatch_count     = 0;
   int send_gap           = 0;
   int stall_burst        = 0;
   int hold_left          = 0;
   bit long_hold_done     = 1'b0;
   int quiet_cycles       = 0;

   // Computes the response to one request and applies its effect on the
   // mirrored queues and statistics counters.
   function automatic mbx_result_type mailbox_response(input mbx_request_type rq);
      mbx_result_type rs;
      msg_entry_type  msg;
      int             tgt;
      int             slot;
      rs = '0;
      tgt = $signed(rq.target);
      case (rq.mode) inside
         MODE_SEND: begin
            if (tgt < 0 || tgt >= NUM_TASKS || rq.size > MAX_PAYLOAD) begin
               rs.status = STATUS_INVALID;
            end else if (mirror_count[tgt] >= QUEUE_DEPTH) begin
               // A full queue is left alone, only the rejection is counted.
               full_tally = full_tally + 32'd1;
               rs.status = STATUS_FULL;
            end else begin
               msg.snd = rq.caller;
               msg.typ = rq.msg_type;
               msg.flg = rq.msg_flags;
               msg.len = rq.size[LEN_W-1:0];
               msg.hdl = rq.handle;
               slot = (mirror_head[tgt] + mirror_count[tgt]) % QUEUE_DEPTH;
               mirror_store[tgt][slot] = msg;
               mirror_count[tgt]++;
               sent_tally = sent_tally + 32'd1;
               rs.status = STATUS_OK;
            end
         end
         MODE_RECEIVE, MODE_PEEK: begin
            if (mirror_count[rq.caller] == 0) begin
               rs.status = STATUS_EMPTY;
            end else begin
               msg = mirror_store[rq.caller][mirror_head[rq.caller]];
               rs.sender     = msg.snd;
               rs.out_type   = msg.typ;
               rs.out_flags  = msg.flg;
               rs.out_size   = msg.len;
               rs.out_handle = msg.hdl;
               if (rq.mode == MODE_RECEIVE) begin
                  mirror_head[rq.caller] = (mirror_head[rq.caller] + 1) % QUEUE_DEPTH;
                  mirror_count[rq.caller]--;
                  received_tally = received_tally + 32'd1;
               end
            end
         end
         MODE_COUNT: begin
            rs.count_value = 5'(mirror_count[rq.caller]);
         end
         MODE_FLUSH: begin
            if (rq.target == FLUSH_SELF) begin
               tgt = rq.caller;
            end
            if (tgt < 0 || tgt >= NUM_TASKS) begin
               rs.status = STATUS_INVALID;
            end else begin
               rs.count_value = 5'(mirror_count[tgt]);
               mirror_head[tgt] = 0;
               mirror_count[tgt] = 0;
            end
         end
         MODE_READ_STATS: begin
            rs.sent_count     = sent_tally;
            rs.received_count = received_tally;
            rs.full_count     = full_tally;
         end
         MODE_CLEAR_STATS: begin
            sent_tally     = '0;
            received_tally = '0;
            full_tally     = '0;
         end
         default: begin
            rs.status = STATUS_INVALID;
         end
      endcase
      return rs;
   endfunction

   // Mostly legal sizes, the maximum now and then, and oversized ones that
   // also exercise the upper size bits.
   function automatic logic [9:0] random_size();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         return 10'($urandom_range(MAX_PAYLOAD + 1, 1023));
      end else if (pick == 2) begin
         return 10'(MAX_PAYLOAD);
      end
      return 10'($urandom_range(0, MAX_PAYLOAD));
   endfunction

   function automatic void queue_item(input logic [2:0] mode, input logic [3:0] caller,
                                      input logic [7:0] target, input logic [7:0] typ,
                                      input logic [7:0] flg, input logic [9:0] size,
                                      input logic [31:0] hdl);
      mbx_request_type rq;
      rq.mode        = mode;
      rq.caller      = caller;
      rq.target      = target;
      rq.msg_type    = typ;
      rq.msg_flags   = flg;
      rq.size        = size;
      rq.handle      = hdl;
      rq.drain_first = 1'b0;
      pending_requests.push_back(rq);
   endfunction

   // Fields that the mode does not use still carry random content.
   function automatic void queue_request(input logic [2:0] mode, input logic [3:0] caller,
                                         input logic [7:0] target);
      queue_item(mode, caller, target, 8'($urandom), 8'($urandom), random_size(), $urandom);
   endfunction

   // Most traffic goes to a few tasks so that their queues fill and wrap.
   function automatic logic [3:0] busy_task();
      if ($urandom_range(0, 3) != 0) begin
         return 4'($urandom_range(0, 3));
      end
      return 4'($urandom_range(0, NUM_TASKS - 1));
   endfunction

   function automatic void mark_drain(input int index);
      mbx_request_type rq;
      rq = pending_requests[index];
      rq.drain_first = 1'b1;
      pending_requests[index] = rq;
   endfunction

   // Idling is switched off in every fourth window of 90 requests and in
   // the tail of the run, which gives stretches at full rate.
   function automatic bit idle_window();
      return (accepted_requests < total_requests - QUIET_TAIL) &&
             ((accepted_requests / 90) % 4 != 3);
   endfunction

   // Driver. A new request is offered only when the previous one has been
   // transferred, so valid never looks at stall and a stalled request holds.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_responses.push_back(mailbox_response(offered_request));
            accepted_requests <= accepted_requests + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests[0].drain_first &&
                         (req_valid || accepted_requests != responses_checked)) begin
               // The sender pauses here until every response has come back.
               req_valid <= 1'b0;
            end else begin
               offered_request = pending_requests.pop_front();
               req_valid          <= 1'b1;
               req_mode           <= offered_request.mode;
               req_caller_task    <= offered_request.caller;
               req_target_task    <= offered_request.target;
               req_msg_type       <= offered_request.msg_type;
               req_msg_flags      <= offered_request.msg_flags;
               req_msg_size       <= offered_request.size;
               req_payload_handle <= offered_request.handle;
               if (idle_window() && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 14);
               end
            end
         end
      end
   end

   // Receiver stall. Once HOLD_AT requests are in, it holds the long stall
   // set by LONG_HOLD while the driver keeps offering, so the block fills up and
   // stalls its own input. Otherwise, where idling is allowed, it stalls in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && accepted_requests >= HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (idle_window() && $urandom_range(0, 4) == 0) begin
         stall_burst = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor. Every transferred response is checked against the oldest
   // expected one; a response with nothing awaited is a failure too.
   always @(posedge clock) begin
      mbx_result_type seen;
      mbx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_status, rsp_sender, rsp_out_type, rsp_out_flags, rsp_out_size,
                 rsp_out_handle, rsp_count_value, rsp_sent_count, rsp_received_count,
                 rsp_full_count};
         responses_checked <= responses_checked + 1;
         if (awaited_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response at %0t: status=%0d", $realtime, seen.status);
            end
         end else begin
            want = awaited_responses.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display({"mismatch at %0t expected: st=%0d snd=%h typ=%h flg=%h",
                            " sz=%0d hdl=%h cnt=%0d sent=%0d rcv=%0d full=%0d"},
                           $realtime, want.status, want.sender, want.out_type,
                           want.out_flags, want.out_size, want.out_handle,
                           want.count_value, want.sent_count, want.received_count,
                           want.full_count);
                  $display({"                  actual:   st=%0d snd=%h typ=%h flg=%h",
                            " sz=%0d hdl=%h cnt=%0d sent=%0d rcv=%0d full=%0d"},
                           seen.status, seen.sender, seen.out_type, seen.out_flags,
                           seen.out_size, seen.out_handle, seen.count_value,
                           seen.sent_count, seen.received_count, seen.full_count);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel transfers anything.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("per_task_mailbox_queues_top test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int kind;
      int n;
      int drain_mark;
      logic [3:0] task_id;

      for (int t = 0; t < NUM_TASKS; t++) begin
         mirror_head[t] = 0;
         mirror_count[t] = 0;
      end
      sent_tally     = '0;
      received_tally = '0;
      full_tally     = '0;

      // Directed opening: empty reads, field extremes on send, every kind of
      // bad target and size, flush of the caller's own queue, a flush of an
      // empty queue, the unused mode and the statistics counters.
      queue_request(MODE_READ_STATS, 4'd0, 8'd0);
      queue_request(MODE_RECEIVE, 4'd0, 8'd0);
      queue_request(MODE_PEEK, 4'd5, 8'd0);
      queue_item(MODE_SEND, 4'd15, 8'd0, 8'hFF, 8'h00, 10'(MAX_PAYLOAD), 32'hFFFF_FFFF);
      queue_item(MODE_SEND, 4'd0, 8'd15, 8'h00, 8'hFF, 10'd0, 32'h0000_0000);
      queue_item(MODE_SEND, 4'd1, 8'd0, 8'hA5, 8'h5A, 10'(MAX_PAYLOAD + 1), 32'h1234_5678);
      queue_item(MODE_SEND, 4'd2, 8'd0, 8'h5A, 8'hA5, 10'd1023, 32'h8765_4321);
      queue_request(MODE_SEND, 4'd3, 8'h80);          // most negative target
      queue_request(MODE_SEND, 4'd3, FLUSH_SELF);     // minus one is not special on send
      queue_request(MODE_SEND, 4'd3, 8'd16);
      queue_request(MODE_SEND, 4'd3, 8'h7F);
      queue_request(MODE_PEEK, 4'd0, 8'd0);
      queue_request(MODE_RECEIVE, 4'd0, 8'd0);
      queue_request(MODE_RECEIVE, 4'd0, 8'd0);
      queue_request(MODE_COUNT, 4'd15, 8'd0);
      queue_request(MODE_FLUSH, 4'd15, FLUSH_SELF);
      queue_request(MODE_COUNT, 4'd15, 8'd0);
      queue_request(MODE_FLUSH, 4'd4, 8'hFE);
      queue_request(MODE_FLUSH, 4'd4, 8'h80);
      queue_request(MODE_FLUSH, 4'd4, 8'd16);
      queue_request(MODE_FLUSH, 4'd4, 8'd3);
      queue_request(MODE_UNUSED, 4'd6, 8'd6);
      queue_request(MODE_READ_STATS, 4'd0, 8'd0);
      queue_request(MODE_CLEAR_STATS, 4'd0, 8'd0);
      queue_request(MODE_READ_STATS, 4'd0, 8'd0);

      // The random part opens with an overfilled queue after a full drain of
      // the directed responses, so a full rejection and a count of sixteen
      // are seen early.
      drain_mark = pending_requests.size();
      for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
         queue_item(MODE_SEND, 4'($urandom), 8'd3, 8'($urandom), 8'($urandom),
                    10'($urandom_range(0, MAX_PAYLOAD)), $urandom);
      end
      mark_drain(drain_mark);
      queue_request(MODE_COUNT, 4'd3, 8'd0);

      while (pending_requests.size() < RANDOM_TARGET) begin
         kind = $urandom_range(0, 99);
         task_id = busy_task();
         if (kind < 30) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               queue_request(MODE_SEND, 4'($urandom), 8'(task_id));
            end
         end else if (kind < 55) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               queue_request(($urandom_range(0, 4) == 0) ? 3'(MODE_PEEK) : 3'(MODE_RECEIVE),
                             task_id, 8'($urandom));
            end
         end else if (kind < 63) begin
            n = $urandom_range(0, 3);
            if (n == 0) begin
               queue_request(MODE_FLUSH, task_id, FLUSH_SELF);
            end else if (n == 1) begin
               queue_request(MODE_FLUSH, 4'($urandom), 8'($urandom));
            end else begin
               queue_request(MODE_FLUSH, 4'($urandom), 8'(task_id));
            end
         end else if (kind < 75) begin
            n = $urandom_range(0, 9);
            if (n < 5) begin
               queue_request(MODE_COUNT, task_id, 8'($urandom));
            end else if (n < 9) begin
               queue_request(MODE_READ_STATS, 4'($urandom), 8'($urandom));
            end else begin
               queue_request(MODE_CLEAR_STATS, 4'($urandom), 8'($urandom));
            end
         end else begin
            queue_request(3'($urandom_range(0, 7)), 4'($urandom), 8'($urandom));
         end
      end

      // A second pause of the sender, well into the run.
      mark_drain(pending_requests.size() / 2);
      total_requests = pending_requests.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be transferred and every response checked,
      // then give the block time to show any stray response.
      while (pending_requests.size() != 0 || req_valid ||
             accepted_requests != responses_checked) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("per_task_mailbox_queues_top test passed");
      end else begin
         $display("per_task_mailbox_queues_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/mbxq_pkg.sv
src/mbxq_ptr_table.sv
src/mbxq_msg_store.sv
src/per_task_mailbox_queues_top.sv
tb/sv/testbench.sv
